// ----- design/i2cts_pkg.sv -----
// types, codes and helpers shared by the i2c transfer sequencer
package i2cts_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 3;

    // event codes
    typedef enum logic [2:0] {
        EV_MWRITE   = 3'd0,
        EV_MREAD    = 3'd1,
        EV_STX_SET  = 3'd2,
        EV_SRX_SET  = 3'd3,
        EV_TXEMPTY  = 3'd4,
        EV_TXEND    = 3'd5,
        EV_RXFULL   = 3'd6,
        EV_STOP     = 3'd7
    } t_req;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ROLE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ADDR    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_HDR     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RETRY   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FILLER  = 3'd4;

    // bus commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_IRST  = 2'd3;

    // nack control
    localparam logic [1:0] NACK_KEEP = 2'd0;
    localparam logic [1:0] NACK_SET  = 2'd1;
    localparam logic [1:0] NACK_ACK  = 2'd2;

    // scl hold control
    localparam logic [1:0] HOLD_KEEP = 2'd0;
    localparam logic [1:0] HOLD_LOW  = 2'd1;
    localparam logic [1:0] HOLD_REL  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ADDR_W     = 4'd1,
        PH_ADDR_R     = 4'd2,
        PH_SEND       = 4'd3,
        PH_SEND_2     = 4'd4,
        PH_SEND_END   = 4'd5,
        PH_RECV       = 4'd6,
        PH_RECV_2     = 4'd7,
        PH_RECV_3     = 4'd8,
        PH_RECV_4     = 4'd9,
        PH_RECV_END   = 4'd10,
        PH_RECV_END_2 = 4'd11
    } t_phase;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [ByteW-1:0] length;
        logic             bus_busy;
        logic             nack_seen;
        logic             stop_seen;
        logic             rx_ready;
        logic [ByteW-1:0] rx_byte;
        logic [ByteW-1:0] tx_byte;
    } t_in_word;

    typedef struct packed {
        logic             tx_write;
        logic [ByteW-1:0] tx_data;
        logic [1:0]       bus_cmd;
        logic [1:0]       nack_ctrl;
        logic [1:0]       hold_ctrl;
        logic             rx_store;
        logic [ByteW-1:0] rx_data;
        logic [ByteW-1:0] rx_index;
        logic             reg_addr_valid;
        logic             stop_notice;
        logic             stop_direction;
        logic [ByteW-1:0] stop_length;
    } t_out_word;

    typedef struct packed {
        logic             role;
        logic [6:0]       addr;
        logic [1:0]       header_bytes;
        logic [ByteW-1:0] retry_limit;
        logic [ByteW-1:0] filler_byte;
    } t_cfg;

    // session restart caused by a role write
    typedef struct packed {
        logic valid;
        logic role;
    } t_restart;

    function automatic logic [ByteW-1:0] sat_inc(input logic [ByteW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- design/i2cts_cfg_regs.sv -----
// configuration register file of the i2c transfer sequencer
module i2cts_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [i2cts_pkg::CfgIdxW-1:0]   i_index,
    input  logic [i2cts_pkg::ByteW-1:0]     i_data,
    output i2cts_pkg::t_cfg                 o_cfg,
    output i2cts_pkg::t_restart             o_restart
);
    import i2cts_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role         <= 1'b0;
            r_cfg.addr         <= '0;
            r_cfg.header_bytes <= 2'd1;
            r_cfg.retry_limit  <= 8'd3;
            r_cfg.filler_byte  <= 8'hFF;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_ROLE:   r_cfg.role         <= i_data[0];
                CFG_ADDR:   r_cfg.addr         <= i_data[6:0];
                CFG_HDR:    r_cfg.header_bytes <= i_data[1:0];
                CFG_RETRY:  r_cfg.retry_limit  <= i_data;
                CFG_FILLER: r_cfg.filler_byte  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
    assign o_restart.valid = i_wr && (i_index == CFG_ROLE);
    assign o_restart.role  = i_data[0];

endmodule

// ----- design/i2cts_seq_core.sv -----
// session state and per-event decision logic of the i2c transfer sequencer
module i2cts_seq_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cts_pkg::t_in_word   i_item,
    input  i2cts_pkg::t_cfg       i_cfg,
    input  i2cts_pkg::t_restart   i_restart,
    output i2cts_pkg::t_out_word  o_result
);
    import i2cts_pkg::*;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_tx_done, n_tx_done;
    logic [7:0] r_tx_tot,  n_tx_tot;
    logic [7:0] r_rx_done, n_rx_done;
    logic [7:0] r_rx_tot,  n_rx_tot;
    logic       r_dir,     n_dir;
    logic       r_src_rdy, n_src_rdy;
    logic [7:0] r_wr_retr, n_wr_retr;
    logic [7:0] r_rd_retr, n_rd_retr;
    t_out_word  res;

    logic [7:0] hdr8;
    logic [7:0] data_idx;
    logic [8:0] cnt9;
    logic [7:0] retr;
    logic [7:0] addr_byte;
    t_req       req;

    assign hdr8      = {6'd0, i_cfg.header_bytes};
    assign data_idx  = r_rx_done - hdr8 - 8'd1;
    assign cnt9      = {1'b0, r_rx_done};
    assign addr_byte = {i_cfg.addr, 1'b0};
    assign req       = t_req'(i_item.req_type);
    assign retr      = (req == EV_MWRITE) ? r_wr_retr : r_rd_retr;

    always_comb begin
        n_phase   = r_phase;
        n_tx_done = r_tx_done;
        n_tx_tot  = r_tx_tot;
        n_rx_done = r_rx_done;
        n_rx_tot  = r_rx_tot;
        n_dir     = r_dir;
        n_src_rdy = r_src_rdy;
        n_wr_retr = r_wr_retr;
        n_rd_retr = r_rd_retr;
        res       = '0;

        unique case (req)
            EV_MWRITE, EV_MREAD: begin
                if (!i_cfg.role) begin
                    if (i_item.bus_busy) begin
                        if (retr < i_cfg.retry_limit) begin
                            if (req == EV_MWRITE) n_wr_retr = r_wr_retr + 8'd1;
                            else                  n_rd_retr = r_rd_retr + 8'd1;
                        end else begin
                            res.bus_cmd = CMD_IRST;
                            n_tx_done = '0; n_tx_tot = '0; n_rx_done = '0; n_rx_tot = '0;
                            n_phase = PH_IDLE;
                            if (req == EV_MWRITE) n_wr_retr = '0;
                            else                  n_rd_retr = '0;
                        end
                    end else if (req == EV_MWRITE) begin
                        n_phase = PH_ADDR_W; n_tx_tot = i_item.length; n_tx_done = '0;
                        res.bus_cmd = CMD_START;
                    end else begin
                        n_phase = PH_ADDR_R; n_rx_tot = i_item.length; n_rx_done = '0;
                        res.bus_cmd = CMD_START;
                    end
                end
            end
            EV_STX_SET: begin
                n_tx_tot  = (i_item.length == '0) ? 8'd1 : i_item.length;
                n_src_rdy = 1'b1;
            end
            EV_SRX_SET: n_rx_tot = i_item.length;
            EV_TXEMPTY: begin
                if (i_cfg.role) begin
                    if (r_phase == PH_RECV) begin
                        res.tx_write = 1'b1;
                        res.tx_data  = r_src_rdy ? i_item.tx_byte : i_cfg.filler_byte;
                        n_tx_done = sat_inc(r_tx_done);
                        n_phase = PH_SEND_2; n_dir = 1'b1;
                    end
                end else if (r_phase == PH_ADDR_W) begin
                    res.tx_write = 1'b1; res.tx_data = addr_byte;
                    n_phase = PH_SEND; n_dir = 1'b1;
                end else if (r_phase == PH_ADDR_R) begin
                    res.tx_write = 1'b1; res.tx_data = addr_byte | 8'd1;
                    n_phase = PH_RECV; n_dir = 1'b0;
                end
            end
            EV_TXEND: begin
                if (i_cfg.role) begin
                    if (i_item.nack_seen) begin
                        n_phase = PH_SEND_END;
                    end else begin
                        res.tx_write = 1'b1;
                        res.tx_data  = (r_src_rdy && r_tx_done < r_tx_tot) ?
                                       i_item.tx_byte : i_cfg.filler_byte;
                        n_tx_done = sat_inc(r_tx_done);
                    end
                end else if (r_phase == PH_SEND) begin
                    if (i_item.nack_seen || r_tx_done == r_tx_tot) begin
                        res.bus_cmd = CMD_STOP; n_phase = PH_SEND_END;
                    end else begin
                        res.tx_write = 1'b1; res.tx_data = i_item.tx_byte;
                        n_tx_done = sat_inc(r_tx_done);
                    end
                end
            end
            EV_RXFULL: begin
                if (i_cfg.role) begin
                    if (r_phase == PH_RECV) begin
                        n_dir = 1'b0;
                        if (r_rx_done == hdr8) begin
                            res.rx_data = i_item.rx_byte; res.reg_addr_valid = 1'b1;
                        end else if (r_rx_done > hdr8) begin
                            if (r_rx_done < r_rx_tot) begin
                                res.rx_store = 1'b1; res.rx_data = i_item.rx_byte;
                                res.rx_index = data_idx;
                            end
                        end else if (r_rx_done == '0) begin
                            n_src_rdy = 1'b0; n_tx_tot = '0;
                        end
                        n_rx_done = sat_inc(r_rx_done);
                    end
                end else if (r_phase == PH_RECV) begin
                    if (i_item.nack_seen) begin
                        res.bus_cmd = CMD_STOP;
                        n_phase = (r_rx_tot <= 8'd2) ? PH_RECV_END_2 : PH_RECV_END;
                    end else if (r_rx_tot <= 8'd2) begin
                        res.hold_ctrl = HOLD_LOW;
                        if (r_rx_tot == 8'd2) begin
                            n_phase = PH_RECV_2;
                        end else begin
                            res.nack_ctrl = NACK_SET; n_phase = PH_RECV_3;
                        end
                    end else begin
                        n_phase = PH_RECV_4;
                    end
                end else if (r_phase == PH_RECV_2 || r_phase == PH_RECV_3 ||
                             r_phase == PH_RECV_4) begin
                    res.rx_store = 1'b1; res.rx_data = i_item.rx_byte;
                    res.rx_index = r_rx_done;
                    n_rx_done = sat_inc(r_rx_done);
                    if (r_phase == PH_RECV_2) begin
                        res.nack_ctrl = NACK_SET; n_phase = PH_RECV_3;
                    end else if (r_phase == PH_RECV_3) begin
                        res.bus_cmd = CMD_STOP; res.nack_ctrl = NACK_SET;
                        res.hold_ctrl = HOLD_REL; n_phase = PH_RECV_END_2;
                    end else if ({1'b0, r_rx_tot} == cnt9 + 9'd1) begin
                        res.bus_cmd = CMD_STOP; res.hold_ctrl = HOLD_REL;
                        n_phase = PH_RECV_END;
                    end else if ({1'b0, r_rx_tot} == cnt9 + 9'd2) begin
                        res.nack_ctrl = NACK_SET;
                    end else if ({1'b0, r_rx_tot} == cnt9 + 9'd3) begin
                        res.hold_ctrl = HOLD_LOW;
                    end
                end
            end
            EV_STOP: begin
                if (i_item.stop_seen) begin
                    res.stop_notice    = 1'b1;
                    res.stop_direction = r_dir;
                    res.stop_length    = (cnt9 > {1'b0, hdr8} + 9'd1) ? data_idx : '0;
                end
                if (i_cfg.role) begin
                    if (r_phase == PH_SEND || r_phase == PH_SEND_2 ||
                        r_phase == PH_SEND_END) begin
                        n_dir = 1'b1;
                        if (i_item.nack_seen) begin
                            n_tx_done = '0; n_tx_tot = '0; n_rx_done = '0; n_rx_tot = '0;
                            n_phase = PH_RECV;
                        end
                    end else if (r_phase == PH_RECV) begin
                        if (i_item.rx_ready && r_rx_done > hdr8 && r_rx_done < r_rx_tot) begin
                            res.rx_store = 1'b1; res.rx_data = i_item.rx_byte;
                            res.rx_index = data_idx;
                        end
                        res.nack_ctrl = NACK_ACK; n_dir = 1'b0;
                        n_tx_done = '0; n_tx_tot = '0; n_rx_done = '0; n_rx_tot = '0;
                        n_phase = PH_RECV;
                    end
                end else if (r_phase == PH_SEND_END || r_phase == PH_RECV_END ||
                             r_phase == PH_RECV_END_2) begin
                    if (i_item.stop_seen) begin
                        if (r_phase == PH_RECV_END_2) res.nack_ctrl = NACK_ACK;
                        n_tx_done = '0; n_tx_tot = '0; n_rx_done = '0; n_rx_tot = '0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tx_done <= '0;
            r_tx_tot  <= '0;
            r_rx_done <= '0;
            r_rx_tot  <= '0;
            r_dir     <= 1'b0;
            r_src_rdy <= 1'b0;
            r_wr_retr <= '0;
            r_rd_retr <= '0;
        end else if (i_restart.valid) begin
            r_phase   <= i_restart.role ? PH_RECV : PH_IDLE;
            r_tx_done <= '0;
            r_tx_tot  <= '0;
            r_rx_done <= '0;
            r_rx_tot  <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_tx_done <= n_tx_done;
            r_tx_tot  <= n_tx_tot;
            r_rx_done <= n_rx_done;
            r_rx_tot  <= n_rx_tot;
            r_dir     <= n_dir;
            r_src_rdy <= n_src_rdy;
            r_wr_retr <= n_wr_retr;
            r_rd_retr <= n_rd_retr;
        end
    end

    assign o_result = res;

endmodule

// ----- design/i2c_transfer_sequencer_top.sv -----
// top level of the i2c transfer sequencer: word registers, config and core
//
// sequences i2c transfers above a byte-level controller, one event word in,
// one command word out
// input channel: i_in_valid / o_in_stall carrying i_in_word (event and flags);
//   a word is taken at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carrying o_out_word (tx byte,
//   bus command, nack and scl hold control, rx store, stop report)
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high, writes are meant for idle periods only, and a
//   role write restarts the session
// path: an accepted word goes through the input register, then the decision
//   logic into the output register
// throughput: one word per cycle while the output is not stalled; the event
//   decision is a single pass of logic over the session registers
// output stall: the output register holds its word; the input register keeps
//   its word, if it holds one, and o_in_stall rises until the output drains
// reset: synchronous, active low; empties both registers, clears the session
//   state and loads the default configuration
module i2c_transfer_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  i2cts_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output i2cts_pkg::t_out_word            o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [i2cts_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [i2cts_pkg::ByteW-1:0]     i_cfg_data
);
    import i2cts_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;
    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      fire;
    logic      in_take;
    t_cfg      cfg;
    t_restart  restart;
    t_out_word result;

    // the held word moves on when the output register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    i2cts_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid && o_cfg_ready),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    i2cts_seq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in_word),
        .i_cfg     (cfg),
        .i_restart (restart),
        .o_result  (result)
    );

    // output register, loaded whenever the core finishes a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // input only backs up behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // unused payload fields read as zero
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.tx_write) |-> (o_out_word.tx_data == '0))
        else $error("tx data without tx write");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.stop_notice) |->
        (o_out_word.stop_length == '0 && !o_out_word.stop_direction))
        else $error("stop report without stop notice");

    // both registers empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("words left after reset");

endmodule
